// ===== rtl/sdfi_pkg.sv =====
// Package for the SD response fault injector.
// Holds the table entry type, status codes and shared constants.
// No dependencies.
`timescale 1ns / 1ps

package sdfi_pkg;

  // Default number of fault table entries
  localparam int SDFI_TABLE_ENTRIES = 32;

  // Response geometry: four 32-bit words, sixteen bytes, 128 bits
  localparam int SDFI_RESP_BYTES = 16;
  localparam int SDFI_RESP_BITS  = 8 * SDFI_RESP_BYTES;

  // Command codes
  localparam logic CMD_INSTALL  = 1'b0;
  localparam logic CMD_RESPONSE = 1'b1;

  // Status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;

  // One fault table entry as kept in the entry memory
  typedef struct packed {
    logic [5:0] opcode;
    logic [4:0] byte_position;
    logic [7:0] byte_value;
    logic [7:0] bit_position;
    logic       bit_value;
  } entry_t;

  // Compare results of one entry against the current word
  typedef struct packed {
    logic op_hit;    // valid entry with the same opcode
    logic inst_hit;  // valid entry that an install overwrites
    logic free;      // entry not in use
  } entry_match_t;

endpackage

// ===== rtl/sdfi_if.sv =====
// Channel interfaces of the SD response fault injector.
// Valid/ready handshake with request and result payloads.
// Depends on nothing.
`timescale 1ns / 1ps

interface sdfi_in_if;
  logic              valid;
  logic              ready;
  logic              command;
  logic [5:0]        opcode;
  logic [31:0]       response_word0;
  logic [31:0]       response_word1;
  logic [31:0]       response_word2;
  logic [31:0]       response_word3;
  logic signed [4:0] byte_position;
  logic [7:0]        byte_value;
  logic signed [7:0] bit_position;
  logic              bit_value;

  modport source (
    output valid, command, opcode, response_word0, response_word1, response_word2,
           response_word3, byte_position, byte_value, bit_position, bit_value,
    input  ready
  );
  modport sink (
    input  valid, command, opcode, response_word0, response_word1, response_word2,
           response_word3, byte_position, byte_value, bit_position, bit_value,
    output ready
  );
endinterface

interface sdfi_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] result_word0;
  logic [31:0] result_word1;
  logic [31:0] result_word2;
  logic [31:0] result_word3;

  modport source (
    output valid, status, result_word0, result_word1, result_word2, result_word3,
    input  ready
  );
  modport sink (
    input  valid, status, result_word0, result_word1, result_word2, result_word3,
    output ready
  );
endinterface

// ===== rtl/sdfi_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// Used for the fault entry table. No dependencies.
`timescale 1ns / 1ps

module sdfi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sdfi_entry_unit.sv =====
// Shared entry unit: compares one table entry against the current word
// and applies its byte write and bit force to the response. Uses sdfi_pkg.
`timescale 1ns / 1ps

module sdfi_entry_unit
  import sdfi_pkg::*;
(
  input  entry_t                    entry_i,
  input  logic                      entry_valid_i,
  input  logic [5:0]                opcode_i,
  input  logic [4:0]                byte_position_i,
  input  logic [7:0]                bit_position_i,
  input  logic [SDFI_RESP_BITS-1:0] words_i,
  output entry_match_t              match_o,
  output logic [SDFI_RESP_BITS-1:0] words_o
);

  logic                      op_eq;
  logic                      byte_present;
  logic                      bit_present;
  logic [SDFI_RESP_BITS-1:0] byte_done;

  assign op_eq        = entry_valid_i && (entry_i.opcode == opcode_i);
  assign byte_present = !entry_i.byte_position[4];
  assign bit_present  = !entry_i.bit_position[7];

  // Compare against the install word; a present offset only equals a present one
  always_comb begin
    match_o.op_hit   = op_eq;
    match_o.free     = !entry_valid_i;
    match_o.inst_hit = op_eq &&
                       ((!bit_position_i[7] && (entry_i.bit_position == bit_position_i)) ||
                        (!byte_position_i[4] && (entry_i.byte_position == byte_position_i)));
  end

  // Overwrite the addressed byte
  always_comb begin
    byte_done = words_i;
    for (int k = 0; k < SDFI_RESP_BYTES; k++) begin
      if (byte_present && (entry_i.byte_position[3:0] == 4'(k))) begin
        byte_done[8*k +: 8] = entry_i.byte_value;
      end
    end
  end

  // Then force the addressed bit
  always_comb begin
    words_o = byte_done;
    for (int j = 0; j < SDFI_RESP_BITS; j++) begin
      if (bit_present && (entry_i.bit_position[6:0] == 7'(j))) begin
        words_o[j] = entry_i.bit_value;
      end
    end
  end

endmodule

// ===== rtl/sd_response_fault_injector.sv =====
// Top level of the SD response fault injector.
// Uses sdfi_pkg, sdfi_if, sdfi_ram and sdfi_entry_unit.
`timescale 1ns / 1ps

// After acceptance, the sequencer reads the fault table one entry per cycle
// through the single read port of the entry memory and runs each entry
// through one shared compare and patch unit. The block takes a new word only
// when the sequencer is idle; a finished result waits in the output register
// while the next word is accepted. The sequencer holds in its finish state
// while the previous result still sits unread in the output register. Entry
// valid bits sit in flip-flops cleared by reset, so no clearing pass is
// needed. Install words report ok, invalid (no offset given) or table full,
// with zero result words; response words return the patched response with
// ok status.
module sd_response_fault_injector
  import sdfi_pkg::*;
#(
  parameter int TABLE_ENTRIES = SDFI_TABLE_ENTRIES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sdfi_in_if.sink    in_i,
  sdfi_out_if.source out_o
);

  localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CntW = $clog2(TABLE_ENTRIES + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]                state_q, state_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic                      pend_q, pend_d;
  logic [IdxW-1:0]           pidx_q, pidx_d;
  logic [TABLE_ENTRIES-1:0]  valid_q, valid_d;

  logic                      cmd_q;
  logic [5:0]                op_q;
  logic [4:0]                bpos_q;
  logic [7:0]                bval_q;
  logic [7:0]                tpos_q;
  logic                      tval_q;
  logic [SDFI_RESP_BITS-1:0] acc_q, acc_d;
  logic                      hit_q, hit_d;
  logic [IdxW-1:0]           hit_idx_q, hit_idx_d;
  logic                      free_q, free_d;
  logic [IdxW-1:0]           free_idx_q, free_idx_d;

  logic                      out_valid_q, out_valid_d;
  logic [1:0]                out_status_q, out_status_d;
  logic [SDFI_RESP_BITS-1:0] out_words_q, out_words_d;

  logic                      accept;
  logic                      fin_go;
  logic                      invalid;
  logic                      ram_we;
  logic [IdxW-1:0]           ram_waddr;
  entry_t                    ram_wdata;
  entry_t                    ram_rdata;
  entry_match_t              match;
  logic [SDFI_RESP_BITS-1:0] patched;

  assign accept  = in_i.valid && in_i.ready;
  assign invalid = bpos_q[4] && tpos_q[7];
  assign fin_go  = (state_q == ST_FIN) && (!out_valid_q || out_o.ready);

  assign in_i.ready = (state_q == ST_IDLE);

  // Entry memory: scan read, install write
  assign ram_we    = fin_go && (cmd_q == CMD_INSTALL) && !invalid && (hit_q || free_q);
  assign ram_waddr = hit_q ? hit_idx_q : free_idx_q;
  assign ram_wdata = '{opcode: op_q, byte_position: bpos_q, byte_value: bval_q,
                       bit_position: tpos_q, bit_value: tval_q};

  sdfi_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(cnt_q[IdxW-1:0]),
    .rdata_o(ram_rdata)
  );

  sdfi_entry_unit u_unit (
    .entry_i        (ram_rdata),
    .entry_valid_i  (valid_q[pidx_q]),
    .opcode_i       (op_q),
    .byte_position_i(bpos_q),
    .bit_position_i (tpos_q),
    .words_i        (acc_q),
    .match_o        (match),
    .words_o        (patched)
  );

  // Sequencer: issue one read per cycle, process the entry read last cycle
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    pend_d     = 1'b0;
    pidx_d     = pidx_q;
    acc_d      = acc_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SCAN;
          cnt_d   = '0;
          hit_d   = 1'b0;
          free_d  = 1'b0;
          if (in_i.command == CMD_RESPONSE) begin
            acc_d = {in_i.response_word3, in_i.response_word2,
                     in_i.response_word1, in_i.response_word0};
          end else begin
            acc_d = '0;
          end
        end
      end
      ST_SCAN: begin
        if (cnt_q < CntW'(TABLE_ENTRIES)) begin
          pend_d = 1'b1;
          pidx_d = cnt_q[IdxW-1:0];
          cnt_d  = cnt_q + 1'b1;
        end else if (!pend_q) begin
          state_d = ST_FIN;
        end
        // Fold in the entry that arrived this cycle
        if (pend_q) begin
          if (cmd_q == CMD_RESPONSE) begin
            if (match.op_hit) begin
              acc_d = patched;
            end
          end else begin
            if (match.inst_hit && !hit_q) begin
              hit_d     = 1'b1;
              hit_idx_d = pidx_q;
            end
            if (match.free && !free_q) begin
              free_d     = 1'b1;
              free_idx_d = pidx_q;
            end
          end
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Mark the installed entry in use
  always_comb begin
    valid_d = valid_q;
    if (ram_we) begin
      valid_d[ram_waddr] = 1'b1;
    end
  end

  // Output register: load on finish, drop when taken
  always_comb begin
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_words_d  = out_words_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (fin_go) begin
      out_valid_d = 1'b1;
      out_words_d = acc_q;
      if (cmd_q == CMD_RESPONSE) begin
        out_status_d = STATUS_OK;
      end else if (invalid) begin
        out_status_d = STATUS_INVALID;
      end else if (hit_q || free_q) begin
        out_status_d = STATUS_OK;
      end else begin
        out_status_d = STATUS_FULL;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
    end
  end

  // Word payload and working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= in_i.command;
      op_q   <= in_i.opcode;
      bpos_q <= in_i.byte_position;
      bval_q <= in_i.byte_value;
      tpos_q <= in_i.bit_position;
      tval_q <= in_i.bit_value;
    end
    pidx_q       <= pidx_d;
    acc_q        <= acc_d;
    hit_idx_q    <= hit_idx_d;
    free_idx_q   <= free_idx_d;
    out_status_q <= out_status_d;
    out_words_q  <= out_words_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_status_q;
  assign out_o.result_word0 = out_words_q[31:0];
  assign out_o.result_word1 = out_words_q[63:32];
  assign out_o.result_word2 = out_words_q[95:64];
  assign out_o.result_word3 = out_words_q[127:96];

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the SD response fault injector.
// Predicts every status and corrupted response from its own copy of the fault table.
// Depends on sdfi_pkg, sdfi_if and the sd_response_fault_injector RTL.
`timescale 1ns / 1ps

module tb_top;
  import sdfi_pkg::*;

  localparam int SCAN_CYCLES    = SDFI_TABLE_ENTRIES + 3;
  localparam int SETTLE_CYCLES  = 2 * SCAN_CYCLES;
  localparam int WATCHDOG_LIMIT = 2000;

  // Opcodes that random words favor, so entries pile up per opcode
  localparam logic [5:0][5:0] OPCODE_POOL = {6'd63, 6'd25, 6'd18, 6'd17, 6'd12, 6'd0};

  // One input word as sent to the block
  typedef struct packed {
    logic              cmd;
    logic [5:0]        opcode;
    logic [127:0]      words;     // word k in bits 32k+31..32k, byte n in 8n+7..8n
    logic signed [4:0] byte_ofs;
    logic [7:0]        byte_val;
    logic signed [7:0] bit_pos;
    logic              bit_val;
  } fault_req_t;

  // One result word
  typedef struct packed {
    logic [1:0]   status;
    logic [127:0] words;
  } fault_rsp_t;

  logic clk;
  logic rst_n;

  sdfi_in_if  in_if ();
  sdfi_out_if out_if ();

  sd_response_fault_injector u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Shadow fault table
  logic       fault_valid [SDFI_TABLE_ENTRIES];
  entry_t     fault_table [SDFI_TABLE_ENTRIES];
  int         fault_count;

  fault_rsp_t pending_results [$];
  fault_rsp_t rsp_seen;
  int         fail_count;
  int         src_idle_pct;
  int         snk_idle_pct;
  int         quiet_cycles;

  // Clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Install one entry into the shadow table and return the status
  function automatic logic [1:0] install_fault(fault_req_t r);
    int   hit;
    int   free_idx;
    int   i;
    logic byte_on;
    logic bit_on;
    hit      = -1;
    free_idx = -1;
    byte_on  = !r.byte_ofs[4];
    bit_on   = !r.bit_pos[7];
    if (!byte_on && !bit_on) return STATUS_INVALID;
    for (i = 0; i < SDFI_TABLE_ENTRIES; i++) begin
      if (!fault_valid[i]) begin
        if (free_idx < 0) free_idx = i;
      end else if (hit < 0 && fault_table[i].opcode == r.opcode &&
                   ((bit_on && fault_table[i].bit_position == r.bit_pos) ||
                    (byte_on && fault_table[i].byte_position == r.byte_ofs))) begin
        hit = i;
      end
    end
    if (hit < 0 && free_idx < 0) return STATUS_FULL;
    if (hit < 0) begin
      hit = free_idx;
      fault_count++;
    end
    fault_valid[hit] = 1'b1;
    fault_table[hit] = '{opcode: r.opcode, byte_position: r.byte_ofs,
                         byte_value: r.byte_val, bit_position: r.bit_pos,
                         bit_value: r.bit_val};
    return STATUS_OK;
  endfunction

  // Apply every matching entry in table order: byte first, then bit
  function automatic logic [127:0] corrupt_response(fault_req_t r);
    logic [127:0] resp;
    int           i;
    resp = r.words;
    for (i = 0; i < SDFI_TABLE_ENTRIES; i++) begin
      if (fault_valid[i] && fault_table[i].opcode == r.opcode) begin
        if (!fault_table[i].byte_position[4])
          resp[8 * fault_table[i].byte_position[3:0] +: 8] = fault_table[i].byte_value;
        if (!fault_table[i].bit_position[7])
          resp[fault_table[i].bit_position[6:0]] = fault_table[i].bit_value;
      end
    end
    return resp;
  endfunction

  function automatic fault_rsp_t injector_step(fault_req_t r);
    fault_rsp_t rsp;
    if (r.cmd == CMD_INSTALL) begin
      rsp.status = install_fault(r);
      rsp.words  = '0;
    end else begin
      rsp.status = STATUS_OK;
      rsp.words  = corrupt_response(r);
    end
    return rsp;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Random word of the given kind; ignored fields get random content too
  function automatic fault_req_t random_request(logic cmd);
    fault_req_t r;
    r.cmd      = cmd;
    r.opcode   = ($urandom_range(99) < 75) ? OPCODE_POOL[$urandom_range(5)]
                                           : 6'($urandom_range(63));
    r.words    = {rand_word(), rand_word(), rand_word(), rand_word()};
    r.byte_val = 8'($urandom);
    r.bit_val  = 1'($urandom);
    r.byte_ofs = ($urandom_range(99) < 70) ? 5'($urandom_range(15)) : -5'sd1;
    r.bit_pos  = ($urandom_range(99) < 70) ? 8'($urandom_range(127)) : -8'sd1;
    return r;
  endfunction

  function automatic fault_req_t mk_install(logic [5:0] op, logic signed [4:0] bpos,
                                            logic [7:0] bval, logic signed [7:0] tpos,
                                            logic tval);
    fault_req_t r;
    r          = random_request(CMD_INSTALL);
    r.opcode   = op;
    r.byte_ofs = bpos;
    r.byte_val = bval;
    r.bit_pos  = tpos;
    r.bit_val  = tval;
    return r;
  endfunction

  function automatic fault_req_t mk_response(logic [5:0] op, logic [127:0] words);
    fault_req_t r;
    r        = random_request(CMD_RESPONSE);
    r.opcode = op;
    r.words  = words;
    return r;
  endfunction

  // Send one word, idling at random first; valid stays high after acceptance
  task automatic send_word(fault_req_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid          <= 1'b1;
    in_if.command        <= r.cmd;
    in_if.opcode         <= r.opcode;
    in_if.response_word0 <= r.words[31:0];
    in_if.response_word1 <= r.words[63:32];
    in_if.response_word2 <= r.words[95:64];
    in_if.response_word3 <= r.words[127:96];
    in_if.byte_position  <= r.byte_ofs;
    in_if.byte_value     <= r.byte_val;
    in_if.bit_position   <= r.bit_pos;
    in_if.bit_value      <= r.bit_val;
    do @(posedge clk); while (!in_if.ready);
    pending_results.push_back(injector_step(r));
  endtask

  // Hold the sender until every predicted result has come back
  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Extremes, both kinds of word, invalid installs, overwrites and ordering
  task automatic test_directed();
    send_word(mk_response(6'd5, {128{1'b1}}));
    send_word(mk_response(6'd0, 128'h0));
    send_word(mk_install(6'd5, -5'sd1, 8'h11, -8'sd1, 1'b1));
    send_word(mk_install(6'd5, 5'sd0, 8'hA5, -8'sd1, 1'b0));
    send_word(mk_install(6'd5, 5'sd15, 8'h3C, -8'sd1, 1'b1));
    send_word(mk_install(6'd5, -5'sd1, 8'h00, 8'sd0, 1'b1));
    send_word(mk_install(6'd5, -5'sd1, 8'hFF, 8'sd127, 1'b0));
    // byte and bit in the same byte: the bit lands after the byte
    send_word(mk_install(6'd63, 5'sd7, 8'hFF, 8'sd56, 1'b0));
    send_word(mk_install(6'd0, 5'sd4, 8'h00, 8'sd127, 1'b1));
    send_word(mk_response(6'd5, 128'h0));
    send_word(mk_response(6'd5, {128{1'b1}}));
    send_word(mk_response(6'd63, {128{1'b1}}));
    send_word(mk_response(6'd63, 128'h0));
    send_word(mk_response(6'd0, {rand_word(), rand_word(), rand_word(), rand_word()}));
    // same opcode and byte offset overwrites the existing entry
    send_word(mk_install(6'd5, 5'sd0, 8'h5A, -8'sd1, 1'b0));
    // bit offset match overwrites, byte offset changes with it
    send_word(mk_install(6'd5, 5'sd3, 8'h77, 8'sd127, 1'b1));
    // both offsets match different entries: the first in table order wins
    send_word(mk_install(6'd5, 5'sd15, 8'hC0, 8'sd0, 1'b0));
    send_word(mk_install(6'd6, 5'sd0, 8'h81, -8'sd1, 1'b0));
    send_word(mk_response(6'd5, {rand_word(), rand_word(), rand_word(), rand_word()}));
    send_word(mk_response(6'd6, {rand_word(), rand_word(), rand_word(), rand_word()}));
    send_word(mk_response(6'd7, {128{1'b1}}));
    send_word(mk_install(6'd63, -5'sd1, 8'hFF, -8'sd1, 1'b1));
    wait_for_results();
  endtask

  // Fill every entry, then overflow, then overwrite an entry of the full table
  task automatic test_table_full();
    fault_req_t r;
    while (fault_count < SDFI_TABLE_ENTRIES) begin
      r        = random_request(CMD_INSTALL);
      r.opcode = 6'($urandom_range(63));
      if (r.byte_ofs[4] && r.bit_pos[7]) r.byte_ofs = 5'($urandom_range(15));
      send_word(r);
    end
    repeat (4) begin
      r        = random_request(CMD_INSTALL);
      r.opcode = 6'($urandom_range(63));
      send_word(r);
    end
    r = mk_install(fault_table[SDFI_TABLE_ENTRIES - 1].opcode,
                   fault_table[SDFI_TABLE_ENTRIES - 1].byte_position, 8'hC3,
                   fault_table[SDFI_TABLE_ENTRIES - 1].bit_position, 1'b1);
    send_word(r);
    send_word(mk_response(r.opcode, {128{1'b1}}));
    wait_for_results();
  endtask

  // Mixed installs and responses under the given idle rates
  task automatic test_random_traffic(int n, int src_pct, int snk_pct);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    repeat (n) begin
      send_word(random_request(($urandom_range(99) < 55) ? CMD_RESPONSE : CMD_INSTALL));
    end
    wait_for_results();
  endtask

  // Receiver stalls at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Check each result word against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: status %0d", out_if.status);
        fail_count++;
      end else begin
        rsp_seen = pending_results.pop_front();
        compare_field("status", 32'(rsp_seen.status), 32'(out_if.status));
        compare_field("result_word0", rsp_seen.words[31:0], out_if.result_word0);
        compare_field("result_word1", rsp_seen.words[63:32], out_if.result_word1);
        compare_field("result_word2", rsp_seen.words[95:64], out_if.result_word2);
        compare_field("result_word3", rsp_seen.words[127:96], out_if.result_word3);
      end
    end
  end

  // Abort when no word moves for too long
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("sd_response_fault_injector regression: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Test sequence
  initial begin
    fail_count   = 0;
    fault_count  = 0;
    src_idle_pct = 13;
    snk_idle_pct = 80;
    for (int i = 0; i < SDFI_TABLE_ENTRIES; i++) fault_valid[i] = 1'b0;
    rst_n                = 1'b0;
    in_if.valid          = 1'b0;
    in_if.command        = CMD_INSTALL;
    in_if.opcode         = '0;
    in_if.response_word0 = '0;
    in_if.response_word1 = '0;
    in_if.response_word2 = '0;
    in_if.response_word3 = '0;
    in_if.byte_position  = '0;
    in_if.byte_value     = '0;
    in_if.bit_position   = '0;
    in_if.bit_value      = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_traffic(450, 13, 80);
    test_table_full();
    test_random_traffic(450, 80, 13);
    test_random_traffic(450, 0, 0);

    // Let any stray result show up
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("sd_response_fault_injector regression: pass");
    end else begin
      $display("sd_response_fault_injector regression: fail");
    end
    $finish;
  end

endmodule
